// ===== src/ppwc_pkg.sv =====
package ppwc_pkg;

    // field widths
    localparam int unsigned IN_W    = 31;
    localparam int unsigned ERR_W   = 32;
    localparam int unsigned GAIN_W  = 32;
    localparam int unsigned PLIM_W  = 31;
    localparam int unsigned ILIM_W  = 39;
    localparam int unsigned INTEG_W = 40;
    localparam int unsigned DRIVE_W = 32;
    localparam int unsigned CFG_W   = 39;
    localparam int unsigned IDX_W   = 3;
    localparam int unsigned FRAC_W  = 16;

    // reset value of the integral clear threshold
    localparam logic signed [ERR_W-1:0] RESET_BELOW_DEFAULT = 32'sd5;

    typedef logic signed [IN_W-1:0]    t_in_val;
    typedef logic signed [DRIVE_W-1:0] t_drive;
    typedef logic [IDX_W-1:0]          t_cfg_addr;
    typedef logic [CFG_W-1:0]          t_cfg_data;

    typedef enum logic [IDX_W-1:0] {
        CFG_KP_GAIN     = 3'd0,
        CFG_KI_GAIN     = 3'd1,
        CFG_KD_GAIN     = 3'd2,
        CFG_P_LIMIT     = 3'd3,
        CFG_I_LIMIT     = 3'd4,
        CFG_RESET_BELOW = 3'd5
    } t_cfg_idx;

endpackage

// ===== src/ppwc_in_if.sv =====
interface ppwc_in_if;
    import ppwc_pkg::*;

    logic    valid;
    logic    ready;
    t_in_val target;
    t_in_val measured;

    modport source (output valid, output target, output measured, input ready);
    modport sink   (input valid, input target, input measured, output ready);
endinterface

// ===== src/ppwc_out_if.sv =====
interface ppwc_out_if;
    import ppwc_pkg::*;

    logic   valid;
    logic   ready;
    t_drive drive;

    modport source (output valid, output drive, input ready);
    modport sink   (input valid, input drive, output ready);
endinterface

// ===== src/positional_pid_with_clamps.sv =====
// Positional PID controller with clamps. Each input transaction carries a target and a
// measured value; the block returns one drive value per input, in order. The error is
// accumulated into a 40-bit integral that is clamped to +-i_limit (or saturated at the
// 40-bit range when i_limit is zero) and cleared whenever the error lies below
// integral_reset_below; the proportional error is clamped to +-p_limit when that is
// nonzero; the derivative is the error minus the previous error. Drive is
// floor((kp*P + ki*I + kd*D) / 2^16) saturated to signed 32 bits, with Q16.16 gains.
// The datapath is a five-stage pipeline (error, state update, multiply, partial sums,
// final sum and saturate) that each input passes through in that order, and one
// transaction is taken every cycle as long as the output is drained. The integral and
// previous-error update in stage one is what sets that rate. Each stage only stalls
// when the stage after it is full, so bubbles are squeezed out and inputs keep being
// taken while a finished drive value waits at the output. Registers are written through
// the plain write port and should only change while no transaction is in flight.
module positional_pid_with_clamps (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  ppwc_pkg::t_cfg_addr i_cfg_idx,
    input  ppwc_pkg::t_cfg_data i_cfg_data,
    ppwc_in_if.sink            i_in,
    ppwc_out_if.source         o_out
);
    import ppwc_pkg::*;

    localparam logic signed [INTEG_W:0] INTEG_MAX = 41'sd549755813887;
    localparam logic signed [INTEG_W:0] INTEG_MIN = -41'sd549755813888;
    localparam logic signed [57:0]      DRIVE_MAX = 58'sd2147483647;
    localparam logic signed [57:0]      DRIVE_MIN = -58'sd2147483648;

    // configuration registers
    logic signed [GAIN_W-1:0] r_kp;
    logic signed [GAIN_W-1:0] r_ki;
    logic signed [GAIN_W-1:0] r_kd;
    logic [PLIM_W-1:0]        r_p_limit;
    logic [ILIM_W-1:0]        r_i_limit;
    logic signed [ERR_W-1:0]  r_reset_below;

    // controller state
    logic signed [INTEG_W-1:0] r_integral;
    logic signed [ERR_W-1:0]   r_prev_err;

    // pipeline valids and per-stage advance
    logic r_v0, r_v1, r_v2, r_v3, r_v4;
    logic rdy0, rdy1, rdy2, rdy3, rdy4;
    logic upd;

    // stage payloads
    logic signed [ERR_W-1:0]   r_err;
    logic signed [ERR_W-1:0]   r_p;
    logic signed [INTEG_W-1:0] r_i;
    logic signed [ERR_W:0]     r_d;
    logic signed [63:0]        r_prod_p;
    logic signed [64:0]        r_prod_d;
    logic signed [55:0]        r_prod_ih;
    logic signed [48:0]        r_prod_il;
    logic signed [65:0]        r_sum_pd;
    logic signed [71:0]        r_sum_i;
    t_drive                    r_drive;

    // combinational next values
    logic signed [ERR_W-1:0]   n_err;
    logic signed [INTEG_W:0]   n_sum;
    logic signed [INTEG_W:0]   n_sat;
    logic signed [INTEG_W:0]   lim41;
    logic signed [INTEG_W-1:0] n_integral;
    logic signed [ERR_W:0]     err33;
    logic signed [ERR_W:0]     plim33;
    logic signed [ERR_W:0]     n_p33;
    logic signed [ERR_W-1:0]   n_p;
    logic signed [ERR_W:0]     n_d;
    logic signed [63:0]        n_prod_p;
    logic signed [64:0]        n_prod_d;
    logic signed [55:0]        n_prod_ih;
    logic signed [48:0]        n_prod_il;
    logic signed [16:0]        i_low17;
    logic signed [23:0]        i_high24;
    logic signed [73:0]        n_total;
    logic signed [57:0]        n_shifted;
    t_drive                    n_drive;

    // ready chain: a stage may load when it is empty or its content moves on
    assign rdy4 = !r_v4 || o_out.ready;
    assign rdy3 = !r_v3 || rdy4;
    assign rdy2 = !r_v2 || rdy3;
    assign rdy1 = !r_v1 || rdy2;
    assign rdy0 = !r_v0 || rdy1;
    assign upd  = r_v0 && rdy1;

    assign i_in.ready  = rdy0;
    assign o_out.valid = r_v4;
    assign o_out.drive = r_drive;

    // configuration writes, unknown indexes ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp          <= '0;
            r_ki          <= '0;
            r_kd          <= '0;
            r_p_limit     <= '0;
            r_i_limit     <= '0;
            r_reset_below <= RESET_BELOW_DEFAULT;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_KP_GAIN:     r_kp          <= i_cfg_data[GAIN_W-1:0];
                CFG_KI_GAIN:     r_ki          <= i_cfg_data[GAIN_W-1:0];
                CFG_KD_GAIN:     r_kd          <= i_cfg_data[GAIN_W-1:0];
                CFG_P_LIMIT:     r_p_limit     <= i_cfg_data[PLIM_W-1:0];
                CFG_I_LIMIT:     r_i_limit     <= i_cfg_data[ILIM_W-1:0];
                CFG_RESET_BELOW: r_reset_below <= i_cfg_data[ERR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // stage 0: error, always fits in 32 bits
    assign n_err = {i_in.target[IN_W-1], i_in.target}
                 - {i_in.measured[IN_W-1], i_in.measured};

    // stage 1: integral accumulate, clamp, clear; proportional clamp; derivative
    always_comb begin
        n_sum = {{(INTEG_W+1-ERR_W){r_err[ERR_W-1]}}, r_err}
              + {r_integral[INTEG_W-1], r_integral};
        lim41 = {2'b00, r_i_limit};
        n_sat = n_sum;
        if (r_i_limit != '0) begin
            if (n_sum > lim41) begin
                n_sat = lim41;
            end else if (n_sum < -lim41) begin
                n_sat = -lim41;
            end
        end else begin
            if (n_sum > INTEG_MAX) begin
                n_sat = INTEG_MAX;
            end else if (n_sum < INTEG_MIN) begin
                n_sat = INTEG_MIN;
            end
        end
        n_integral = n_sat[INTEG_W-1:0];
        // every error below the threshold clears the sum, negative ones included
        if (r_err < r_reset_below) begin
            n_integral = '0;
        end

        err33  = {r_err[ERR_W-1], r_err};
        plim33 = {2'b00, r_p_limit};
        n_p33  = err33;
        if (r_p_limit != '0) begin
            if (err33 > plim33) begin
                n_p33 = plim33;
            end else if (err33 < -plim33) begin
                n_p33 = -plim33;
            end
        end
        n_p = n_p33[ERR_W-1:0];

        n_d = err33 - {r_prev_err[ERR_W-1], r_prev_err};
    end

    // stage 2: products, ki*I split at bit 16 to keep each multiplier near 32x32
    assign i_high24  = r_i[INTEG_W-1:FRAC_W];
    assign i_low17   = {1'b0, r_i[FRAC_W-1:0]};
    assign n_prod_p  = r_kp * r_p;
    assign n_prod_d  = r_kd * r_d;
    assign n_prod_ih = r_ki * i_high24;
    assign n_prod_il = r_ki * i_low17;

    // stage 4: final sum, floor shift by 16 is the upper bits, saturate
    always_comb begin
        n_total   = 74'(r_sum_pd) + 74'(r_sum_i);
        n_shifted = n_total[73:FRAC_W];
        if (n_shifted > DRIVE_MAX) begin
            n_drive = DRIVE_MAX[DRIVE_W-1:0];
        end else if (n_shifted < DRIVE_MIN) begin
            n_drive = DRIVE_MIN[DRIVE_W-1:0];
        end else begin
            n_drive = n_shifted[DRIVE_W-1:0];
        end
    end

    // pipeline valids and controller state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0       <= 1'b0;
            r_v1       <= 1'b0;
            r_v2       <= 1'b0;
            r_v3       <= 1'b0;
            r_v4       <= 1'b0;
            r_integral <= '0;
            r_prev_err <= '0;
        end else begin
            if (rdy0) begin
                r_v0 <= i_in.valid;
            end
            if (rdy1) begin
                r_v1 <= r_v0;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
            if (rdy3) begin
                r_v3 <= r_v2;
            end
            if (rdy4) begin
                r_v4 <= r_v3;
            end
            if (upd) begin
                r_integral <= n_integral;
                r_prev_err <= r_err;
            end
        end
    end

    // pipeline payloads
    always_ff @(posedge i_clk) begin
        if (rdy0 && i_in.valid) begin
            r_err <= n_err;
        end
        if (upd) begin
            r_p <= n_p;
            r_i <= n_integral;
            r_d <= n_d;
        end
        if (rdy2 && r_v1) begin
            r_prod_p  <= n_prod_p;
            r_prod_d  <= n_prod_d;
            r_prod_ih <= n_prod_ih;
            r_prod_il <= n_prod_il;
        end
        if (rdy3 && r_v2) begin
            r_sum_pd <= 66'(r_prod_p) + 66'(r_prod_d);
            r_sum_i  <= (72'(r_prod_ih) <<< FRAC_W) + 72'(r_prod_il);
        end
        if (rdy4 && r_v3) begin
            r_drive <= n_drive;
        end
    end

    // integral cleared after an update whose error lies below the threshold
    a_integral_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (upd && (r_err < r_reset_below)) |=> (r_integral == '0))
        else $error("integral not cleared below threshold");

    // integral stays within a nonzero limit after each update
    a_integral_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (upd && (r_i_limit != '0)) |=>
            ((r_integral <= $signed({1'b0, $past(r_i_limit)}))
            && (r_integral >= -$signed({1'b0, $past(r_i_limit)}))))
        else $error("integral outside its limit");

    // previous error tracks the error of the item just taken into stage one
    a_prev_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        upd |=> (r_prev_err == $past(r_err)))
        else $error("previous error not updated");

    // input is only refused when every stage holds an item
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !rdy0 |-> (r_v0 && r_v1 && r_v2 && r_v3 && r_v4))
        else $error("input refused with a bubble in the pipeline");

endmodule

// ===== sim/ppwc_drive_checker.sv =====
module ppwc_drive_checker
    import ppwc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  t_cfg_addr i_cfg_idx,
    input  t_cfg_data i_cfg_data,
    ppwc_in_if        in_mon,
    ppwc_out_if       out_mon,
    output int        o_err_count,
    output int        o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint FRAC_MASK = 64'hFFFF;
    localparam longint INTEG_MAX = (64'sd1 <<< (INTEG_W - 1)) - 64'sd1;
    localparam longint INTEG_MIN = -(64'sd1 <<< (INTEG_W - 1));
    localparam longint HI_BOUND  = 64'sd1 <<< 40;
    localparam longint DRIVE_MAX = 64'sd2147483647;
    localparam longint DRIVE_MIN = -64'sd2147483648;

    // mirrored register file
    logic signed [GAIN_W-1:0]  kp_gain;
    logic signed [GAIN_W-1:0]  ki_gain;
    logic signed [GAIN_W-1:0]  kd_gain;
    logic        [PLIM_W-1:0]  p_limit;
    logic        [ILIM_W-1:0]  i_limit;
    logic signed [ERR_W-1:0]   clear_below;

    // controller state
    logic signed [INTEG_W-1:0] integ_sum;
    logic signed [ERR_W-1:0]   prev_err;

    t_drive drive_expect_q[$];
    t_drive want;
    int     mismatch_cnt = 0;

    function automatic t_drive predict_drive(input t_in_val tgt, input t_in_val meas);
        longint err, p_term, d_term, acc, plim, ilim;
        longint hi_sum, lo_sum, total;
        err  = longint'(tgt) - longint'(meas);
        plim = longint'(p_limit);
        ilim = longint'(i_limit);

        acc = longint'(integ_sum) + err;
        if (ilim != 0) begin
            if (acc > ilim) acc = ilim;
            else if (acc < -ilim) acc = -ilim;
        end else begin
            if (acc > INTEG_MAX) acc = INTEG_MAX;
            else if (acc < INTEG_MIN) acc = INTEG_MIN;
        end

        p_term = err;
        if (plim != 0) begin
            if (p_term > plim) p_term = plim;
            else if (p_term < -plim) p_term = -plim;
        end

        // clear applies after the clamps and is what gets kept
        if (err < longint'(clear_below)) acc = 0;

        d_term    = err - longint'(prev_err);
        integ_sum = acc[INTEG_W-1:0];
        prev_err  = err[ERR_W-1:0];

        // exact split: high parts carry weight 2^16, low parts are 0..65535
        hi_sum = longint'(kp_gain) * (p_term >>> FRAC_W)
               + longint'(ki_gain) * (acc >>> FRAC_W)
               + longint'(kd_gain) * (d_term >>> FRAC_W);
        lo_sum = longint'(kp_gain) * (p_term & FRAC_MASK)
               + longint'(ki_gain) * (acc & FRAC_MASK)
               + longint'(kd_gain) * (d_term & FRAC_MASK);

        total = hi_sum;
        if (total > HI_BOUND) total = HI_BOUND;
        else if (total < -HI_BOUND) total = -HI_BOUND;
        total = total + (lo_sum >>> FRAC_W);
        if (total > DRIVE_MAX) total = DRIVE_MAX;
        else if (total < DRIVE_MIN) total = DRIVE_MIN;
        return total[DRIVE_W-1:0];
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            kp_gain     = '0;
            ki_gain     = '0;
            kd_gain     = '0;
            p_limit     = '0;
            i_limit     = '0;
            clear_below = RESET_BELOW_DEFAULT;
            integ_sum   = '0;
            prev_err    = '0;
            drive_expect_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_KP_GAIN:     kp_gain     = i_cfg_data[GAIN_W-1:0];
                    CFG_KI_GAIN:     ki_gain     = i_cfg_data[GAIN_W-1:0];
                    CFG_KD_GAIN:     kd_gain     = i_cfg_data[GAIN_W-1:0];
                    CFG_P_LIMIT:     p_limit     = i_cfg_data[PLIM_W-1:0];
                    CFG_I_LIMIT:     i_limit     = i_cfg_data[ILIM_W-1:0];
                    CFG_RESET_BELOW: clear_below = i_cfg_data[ERR_W-1:0];
                    default: ;
                endcase
            end
            if (in_mon.valid && in_mon.ready) begin
                drive_expect_q.push_back(predict_drive(in_mon.target, in_mon.measured));
            end
            if (out_mon.valid && out_mon.ready) begin
                if (drive_expect_q.size() == 0) begin
                    mismatch_cnt++;
                    $error("drive: expected none actual %0d", out_mon.drive);
                end else begin
                    want = drive_expect_q.pop_front();
                    if (out_mon.drive !== want) begin
                        mismatch_cnt++;
                        $error("drive: expected %0d actual %0d", want, out_mon.drive);
                    end
                end
            end
        end
        o_pending   <= drive_expect_q.size();
        o_err_count <= mismatch_cnt;
    end

endmodule

// ===== sim/positional_pid_with_clamps_tb.sv =====
module positional_pid_with_clamps_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ppwc_pkg::*;

    // timing of the run
    localparam int CLK_HALF       = 4;
    localparam int RESET_CYCLES   = 6;
    localparam int DRAIN_CYCLES   = 8;     // pipeline is five stages deep
    localparam int HOLD_CYCLES    = 60;    // long output stall, fills the pipeline
    localparam int WATCHDOG_LIMIT = 2000;  // cycles without any transaction

    // stimulus sizes
    localparam int SAT_ITEMS   = 280;      // enough max errors to hit the 40-bit rail
    localparam int RAND_PHASES = 6;
    localparam int RAND_ITEMS  = 90;

    // register indexes with no register behind them
    localparam t_cfg_addr REG_UNMAPPED_LO = 3'd6;
    localparam t_cfg_addr REG_UNMAPPED_HI = 3'd7;

    // field extremes
    localparam t_in_val             IN_MAX   = {1'b0, {(IN_W-1){1'b1}}};
    localparam t_in_val             IN_MIN   = {1'b1, {(IN_W-1){1'b0}}};
    localparam logic [GAIN_W-1:0]   WORD_MAX = 32'h7FFF_FFFF;
    localparam logic [GAIN_W-1:0]   WORD_MIN = 32'h8000_0000;
    localparam logic [GAIN_W-1:0]   Q_ONE    = 32'h0001_0000;
    localparam logic [PLIM_W-1:0]   PLIM_MAX = '1;
    localparam logic [ILIM_W-1:0]   ILIM_MAX = '1;
    localparam longint              ERR_SPAN = 64'sd2147483647;

    typedef enum {
        SHAPE_FULL,
        SHAPE_NEAR_THR,
        SHAPE_EXTREME,
        SHAPE_PUSH_UP,
        SHAPE_PUSH_DOWN,
        SHAPE_MIXED
    } t_shape;

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      cfg_we;
    t_cfg_addr cfg_idx;
    t_cfg_data cfg_data;

    ppwc_in_if  in_if();
    ppwc_out_if out_if();

    int  err_count;
    int  pending;
    int  quiet_cycles = 0;

    // knobs shared by the stimulus and the output side
    bit  idle_on    = 1'b1;
    bit  hold_armed = 1'b0;
    bit  hold_spent = 1'b0;
    logic signed [ERR_W-1:0] cur_thr = RESET_BELOW_DEFAULT;

    always #(CLK_HALF) i_clk = ~i_clk;

    positional_pid_with_clamps u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    ppwc_drive_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .in_mon      (in_if),
        .out_mon     (out_if),
        .o_err_count (err_count),
        .o_pending   (pending)
    );

    // ---------------------------------------------------------------
    // random picks for register values, weighted toward the extremes
    // ---------------------------------------------------------------
    function automatic logic [GAIN_W-1:0] pick_word();
        int small_v;
        small_v = int'($urandom_range(0, 1 << 19)) - (1 << 18);   // about +-4.0 in Q16.16
        case ($urandom_range(0, 7))
            0:       return WORD_MIN;
            1:       return WORD_MAX;
            2:       return '0;
            3:       return Q_ONE;
            4:       return small_v;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [PLIM_W-1:0] pick_plim();
        logic [31:0] rnd;
        rnd = $urandom;
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return PLIM_MAX;
            2:       return PLIM_W'(rnd[9:0]);
            default: return rnd[PLIM_W-1:0];
        endcase
    endfunction

    function automatic logic [ILIM_W-1:0] pick_ilim();
        logic [31:0] rnd_hi, rnd_lo;
        rnd_hi = $urandom;
        rnd_lo = $urandom;
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return ILIM_MAX;
            2:       return ILIM_W'(rnd_lo[16:0]);
            default: return {rnd_hi[ILIM_W-33:0], rnd_lo};
        endcase
    endfunction

    // threshold: close to zero half the time so both sides of it show up
    function automatic logic [ERR_W-1:0] pick_thr();
        int near_v;
        near_v = int'($urandom_range(0, 20)) - 10;
        case ($urandom_range(0, 7))
            0:          return WORD_MIN;
            1:          return WORD_MAX;
            2, 3, 4, 5: return near_v;
            default:    return $urandom;
        endcase
    endfunction

    function automatic t_in_val pick_operand();
        logic [31:0] rnd;
        rnd = $urandom;
        case ($urandom_range(0, 5))
            0:       return IN_MIN;
            1:       return IN_MAX;
            2:       return '0;
            3:       return '1;
            4:       return t_in_val'(1);
            default: return rnd[IN_W-1:0];
        endcase
    endfunction

    // ---------------------------------------------------------------
    // register port
    // ---------------------------------------------------------------
    task automatic write_reg(input t_cfg_addr idx, input t_cfg_data data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
    endtask

    // writes every register, with junk above the width of each register narrower than the port, plus one
    // write to an unmapped index that must leave everything alone
    task automatic program_regs(
        input logic [GAIN_W-1:0] kp,
        input logic [GAIN_W-1:0] ki,
        input logic [GAIN_W-1:0] kd,
        input logic [PLIM_W-1:0] plim,
        input logic [ILIM_W-1:0] ilim,
        input logic [ERR_W-1:0]  thr
    );
        logic [31:0] junk;
        junk = $urandom;
        write_reg(CFG_KP_GAIN,     {junk[CFG_W-GAIN_W-1:0], kp});
        write_reg(CFG_KI_GAIN,     {junk[CFG_W-GAIN_W:1], ki});
        write_reg(CFG_KD_GAIN,     {junk[CFG_W-GAIN_W+1:2], kd});
        write_reg(CFG_P_LIMIT,     {junk[CFG_W-PLIM_W-1:0], plim});
        write_reg(CFG_I_LIMIT,     ilim);
        write_reg(CFG_RESET_BELOW, {junk[CFG_W-ERR_W+2:3], thr});
        write_reg($urandom_range(0, 1) ? REG_UNMAPPED_LO : REG_UNMAPPED_HI,
                  {junk[CFG_W-33:0], junk});
        cfg_we  <= 1'b0;
        cur_thr = thr;
    endtask

    // ---------------------------------------------------------------
    // input side
    // ---------------------------------------------------------------
    task automatic send_item(input t_in_val tgt, input t_in_val meas);
        // when idling is on, now and then a random gap before offering the transaction
        if (idle_on && $urandom_range(0, 3) == 0) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        in_if.valid    <= 1'b1;
        in_if.target   <= tgt;
        in_if.measured <= meas;
        do @(posedge i_clk); while (!in_if.ready);
    endtask

    task automatic gen_operands(input t_shape shape, output t_in_val tgt, output t_in_val meas);
        logic [31:0] r1, r2;
        longint      err_want, lo_v, hi_v;
        r1 = $urandom;
        r2 = $urandom;
        case (shape)
            SHAPE_FULL: begin
                tgt  = r1[IN_W-1:0];
                meas = r2[IN_W-1:0];
            end
            SHAPE_EXTREME: begin
                tgt  = pick_operand();
                meas = pick_operand();
            end
            // near-maximum errors of one sign, walks the integral to a rail
            SHAPE_PUSH_UP: begin
                tgt  = IN_MAX - t_in_val'(r1[15:0]);
                meas = IN_MIN + t_in_val'(r2[15:0]);
            end
            SHAPE_PUSH_DOWN: begin
                tgt  = IN_MIN + t_in_val'(r1[15:0]);
                meas = IN_MAX - t_in_val'(r2[15:0]);
            end
            default: begin
                // error within a few counts of the clear threshold
                err_want = longint'(cur_thr) + longint'(r1[3:0]) - 8;
                if (err_want > ERR_SPAN) err_want = ERR_SPAN;
                if (err_want < -ERR_SPAN) err_want = -ERR_SPAN;
                if (err_want >= 0) begin
                    lo_v = longint'(IN_MIN) + longint'(r2) % (ERR_SPAN - err_want + 1);
                    hi_v = lo_v + err_want;
                    tgt  = hi_v[IN_W-1:0];
                    meas = lo_v[IN_W-1:0];
                end else begin
                    lo_v = longint'(IN_MIN) + longint'(r2) % (ERR_SPAN + err_want + 1);
                    hi_v = lo_v - err_want;
                    tgt  = lo_v[IN_W-1:0];
                    meas = hi_v[IN_W-1:0];
                end
            end
        endcase
    endtask

    task automatic run_items(input int count, input t_shape shape);
        t_in_val tgt, meas;
        t_shape  sel;
        for (int n = 0; n < count; n++) begin
            sel = shape;
            if (shape == SHAPE_MIXED) begin
                case ($urandom_range(0, 7))
                    0, 1, 2, 3: sel = SHAPE_FULL;
                    4, 5:       sel = SHAPE_NEAR_THR;
                    6:          sel = SHAPE_EXTREME;
                    default:    sel = $urandom_range(0, 1) ? SHAPE_PUSH_UP : SHAPE_PUSH_DOWN;
                endcase
            end
            gen_operands(sel, tgt, meas);
            send_item(tgt, meas);
        end
        in_if.valid <= 1'b0;
    endtask

    // every expected drive value back, then let the pipeline go quiet
    task automatic wait_drained();
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // ---------------------------------------------------------------
    // output side: random ready bursts, plus one long hold when armed
    // ---------------------------------------------------------------
    initial begin
        forever begin
            if (hold_armed && !hold_spent) begin
                out_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_spent = 1'b1;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                out_if.ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
            end else begin
                out_if.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // ---------------------------------------------------------------
    // watchdog: too long without any transaction on either channel
    // ---------------------------------------------------------------
    initial begin
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("DONE: errors detected");
        $finish;
    end

    // ---------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------
    initial begin
        i_rst_n        <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_idx        <= '0;
        cfg_data       <= '0;
        in_if.valid    <= 1'b0;
        in_if.target   <= '0;
        in_if.measured <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: no clamps, default threshold, mixed-sign gains
        program_regs(32'h0001_8000, 32'h0000_0100, 32'hFFFE_0000, '0, '0,
                     RESET_BELOW_DEFAULT);
        send_item('0, '0);                      // zero error, integral cleared
        send_item(t_in_val'(5), '0);            // error at threshold, kept
        send_item(t_in_val'(4), '0);            // one below threshold, cleared
        send_item(IN_MAX, IN_MIN);              // largest positive error
        send_item(IN_MAX, IN_MIN);
        send_item(IN_MIN, IN_MAX);              // largest negative error, big derivative
        send_item(IN_MAX, IN_MAX);
        send_item(IN_MIN, IN_MIN);
        send_item(IN_MAX, '0);
        send_item('0, IN_MIN);
        send_item(IN_MIN, '0);
        send_item('0, IN_MAX);
        send_item(t_in_val'(65535), '0);        // low half of the split all ones
        send_item(t_in_val'(65536), '0);        // low half zero
        send_item(t_in_val'(-65537), '0);       // negative with nonzero low half
        send_item('1, '0);                      // small negative error
        in_if.valid <= 1'b0;
        wait_drained();

        // directed: extreme gains, tight clamps on both terms, clear never fires
        program_regs(WORD_MAX, WORD_MAX, WORD_MIN, 31'd100, 39'd1000, WORD_MIN);
        send_item(IN_MAX, IN_MIN);              // proportional and integral clamp high
        send_item(IN_MAX, IN_MIN);
        send_item(IN_MIN, IN_MAX);              // both clamp low
        send_item(IN_MIN, IN_MAX);
        send_item(t_in_val'(50), '0);           // inside both clamps
        send_item(t_in_val'(-50), '0);
        send_item(t_in_val'(200), '0);
        send_item(t_in_val'(200), '0);
        send_item(t_in_val'(-200), '0);
        in_if.valid <= 1'b0;
        wait_drained();

        // unlimited integral driven into its 40-bit positive rail
        program_regs(pick_word(), Q_ONE, pick_word(), pick_plim(), '0, WORD_MIN);
        run_items(SAT_ITEMS, SHAPE_PUSH_UP);
        wait_drained();

        // one negative error under the default threshold empties the integral
        program_regs(pick_word(), Q_ONE, pick_word(), pick_plim(), '0, RESET_BELOW_DEFAULT);
        send_item('0, t_in_val'(1));
        in_if.valid <= 1'b0;
        wait_drained();

        // and down to the negative rail
        program_regs(pick_word(), Q_ONE, pick_word(), pick_plim(), '0, WORD_MIN);
        run_items(SAT_ITEMS, SHAPE_PUSH_DOWN);
        wait_drained();

        // random settings and mixed operands; the last phases run without idling
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            program_regs(pick_word(), pick_word(), pick_word(), pick_plim(), pick_ilim(),
                         pick_thr());
            idle_on    = (ph < RAND_PHASES - 2);
            hold_armed = (ph == 1);             // long output stall backs up the input
            run_items(RAND_ITEMS, SHAPE_MIXED);
            wait_drained();
        end

        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== files.f =====
src/ppwc_pkg.sv
src/ppwc_in_if.sv
src/ppwc_out_if.sv
src/positional_pid_with_clamps.sv
sim/ppwc_drive_checker.sv
sim/positional_pid_with_clamps_tb.sv
